// ----- hw/rtl/fbfla_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfla_pkg
// Shared types and constants for the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 256;

   localparam int CMD_W       = 2;
   localparam int IDX_W       = 8;
   localparam int COUNT_W     = 9;
   localparam int BYTES_W     = 16;
   localparam int BYTE_CNT_W  = 24;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 16'd8;
   localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT = 9'd256;
   localparam logic [BYTES_W-1:0] RESET_BLOCK_BYTES = 16'd16;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_BYTES = 2'd1;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_BAD_FREE,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   index;
   } op_entry_type;

endpackage

// ----- hw/rtl/fbfla_front.sv -----
// ----------------------------------------------------------------------------
// fbfla_front
// Accepts request items, decodes the command and range-checks free indexes.
// ----------------------------------------------------------------------------
module fbfla_front #(
   parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fbfla_pkg::CMD_W-1:0]          req_command,
   input  logic [fbfla_pkg::IDX_W-1:0]          req_block_index,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]      eff_count,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output fbfla_pkg::op_entry_type              push_entry
);
   import fbfla_pkg::*;

   logic         stage_valid_ff, stage_valid_in;
   op_entry_type stage_entry_ff, stage_entry_in;
   op_entry_type decoded;
   logic         accept;

   always_comb begin
      decoded.index = req_block_index;
      case (req_command)
         CMD_ALLOC: decoded.op = OP_ALLOC;
         CMD_FREE: begin
            if (32'(req_block_index) >= 32'(eff_count)) decoded.op = OP_BAD_FREE;
            else decoded.op = OP_FREE;
         end
         CMD_CLEAR: decoded.op = OP_CLEAR;
         default: decoded.op = OP_NOP;
      endcase
   end

   assign req_ready  = !stage_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_entry = stage_entry_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_entry_in = stage_entry_ff;
      if (push_ready) stage_valid_in = 1'b0;
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_entry_in = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_entry_ff <= stage_entry_in;
   end

endmodule

// ----- hw/rtl/fbfla_queue.sv -----
// ----------------------------------------------------------------------------
// fbfla_queue
// Short FIFO of decoded items between the front and back parts.
// ----------------------------------------------------------------------------
module fbfla_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  fbfla_pkg::op_entry_type  push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output fbfla_pkg::op_entry_type  pop_entry
);
   import fbfla_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   op_entry_type     slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ----- hw/rtl/fbfla_back.sv -----
// ----------------------------------------------------------------------------
// fbfla_back
// Executes decoded items on the link memory, keeps head and count, and
// builds the result item.
// ----------------------------------------------------------------------------
module fbfla_back #(
   parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]      eff_count,
   input  logic [fbfla_pkg::BYTES_W-1:0]        eff_bytes,
   input  logic                                 relink,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  fbfla_pkg::op_entry_type              pop_entry,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fbfla_pkg::IDX_W-1:0]          rsp_granted_index,
   output logic [fbfla_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fbfla_pkg::COUNT_W-1:0]        rsp_allocated_blocks,
   output logic [fbfla_pkg::COUNT_W-1:0]        rsp_remaining_blocks,
   output logic [fbfla_pkg::BYTE_CNT_W-1:0]     rsp_allocated_bytes,
   output logic [fbfla_pkg::BYTE_CNT_W-1:0]     rsp_remaining_bytes
);
   import fbfla_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam int PROD_W = CNT_W + BYTES_W;
   localparam logic [CNT_W-1:0] LINK_NONE = CNT_W'(MAX_BLOCKS);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_OUT
   } state_type;

   logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
   logic [CNT_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CNT_W-1:0] mem_wdata;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ptr_ff, sweep_ptr_in;
   logic              sweep_pend_ff, sweep_pend_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  alloc_ff, alloc_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [IDX_W-1:0]  granted_ff, granted_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PROD_W-1:0] prod_alloc_ff, prod_alloc_in;
   logic [PROD_W-1:0] prod_remain_ff, prod_remain_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_granted_ff, rsp_granted_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_alloc_blk_ff, rsp_alloc_blk_in;
   logic [COUNT_W-1:0]    rsp_remain_blk_ff, rsp_remain_blk_in;
   logic [BYTE_CNT_W-1:0] rsp_alloc_byt_ff, rsp_alloc_byt_in;
   logic [BYTE_CNT_W-1:0] rsp_remain_byt_ff, rsp_remain_byt_in;

   logic [CNT_W-1:0] sweep_next;
   logic             sweep_done;

   assign sweep_next = CNT_W'(sweep_ptr_ff) + CNT_W'(1);
   assign sweep_done = (sweep_next >= eff_count);

   always_comb begin
      state_in          = state_ff;
      sweep_ptr_in      = sweep_ptr_ff;
      sweep_pend_in     = sweep_pend_ff;
      head_in           = head_ff;
      alloc_in          = alloc_ff;
      granted_in        = granted_ff;
      status_in         = status_ff;
      prod_alloc_in     = prod_alloc_ff;
      prod_remain_in    = prod_remain_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_granted_in    = rsp_granted_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_alloc_blk_in  = rsp_alloc_blk_ff;
      rsp_remain_blk_in = rsp_remain_blk_ff;
      rsp_alloc_byt_in  = rsp_alloc_byt_ff;
      rsp_remain_byt_in = rsp_remain_byt_ff;
      pop_ready         = 1'b0;
      mem_we            = 1'b0;
      mem_waddr         = sweep_ptr_ff;
      mem_wdata         = sweep_done ? LINK_NONE : sweep_next;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            mem_we       = 1'b1;
            sweep_ptr_in = sweep_ptr_ff + ADDR_W'(1);
            if (sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               granted_in = '0;
               status_in  = STATUS_OK;
               state_in   = ST_MUL;
               case (pop_entry.op)
                  OP_ALLOC: begin
                     if (head_ff == LINK_NONE || alloc_ff >= eff_count) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        granted_in = IDX_W'(head_ff);
                        state_in   = ST_READ;
                     end
                  end
                  OP_FREE: begin
                     if (alloc_ff == '0) begin
                        status_in = STATUS_BAD_FREE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(pop_entry.index);
                        mem_wdata = head_ff;
                        head_in   = CNT_W'(pop_entry.index);
                        alloc_in  = alloc_ff - CNT_W'(1);
                     end
                  end
                  OP_BAD_FREE: status_in = STATUS_BAD_FREE;
                  OP_CLEAR: begin
                     head_in       = '0;
                     alloc_in      = '0;
                     sweep_pend_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            head_in  = rd_data_ff;
            alloc_in = alloc_ff + CNT_W'(1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_alloc_in  = PROD_W'(alloc_ff) * PROD_W'(eff_bytes);
            prod_remain_in = PROD_W'(remain_ff) * PROD_W'(eff_bytes);
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_granted_in    = granted_ff;
               rsp_status_in     = status_ff;
               rsp_alloc_blk_in  = COUNT_W'(alloc_ff);
               rsp_remain_blk_in = COUNT_W'(remain_ff);
               rsp_alloc_byt_in  = BYTE_CNT_W'(prod_alloc_ff);
               rsp_remain_byt_in = BYTE_CNT_W'(prod_remain_ff);
               sweep_ptr_in      = '0;
               sweep_pend_in     = 1'b0;
               state_in          = sweep_pend_ff ? ST_SWEEP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (relink) begin
         state_in      = ST_SWEEP;
         sweep_ptr_in  = '0;
         sweep_pend_in = 1'b0;
         head_in       = '0;
         alloc_in      = '0;
      end

      remain_in = (alloc_in <= eff_count) ? eff_count - alloc_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ptr_ff  <= '0;
         sweep_pend_ff <= 1'b0;
         head_ff       <= '0;
         alloc_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ptr_ff  <= sweep_ptr_in;
         sweep_pend_ff <= sweep_pend_in;
         head_ff       <= head_in;
         alloc_ff      <= alloc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      remain_ff         <= remain_in;
      granted_ff        <= granted_in;
      status_ff         <= status_in;
      prod_alloc_ff     <= prod_alloc_in;
      prod_remain_ff    <= prod_remain_in;
      rsp_granted_ff    <= rsp_granted_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_alloc_blk_ff  <= rsp_alloc_blk_in;
      rsp_remain_blk_ff <= rsp_remain_blk_in;
      rsp_alloc_byt_ff  <= rsp_alloc_byt_in;
      rsp_remain_byt_ff <= rsp_remain_byt_in;
   end

   // link memory: one write port, one registered read port at the head
   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= link_mem[head_ff[ADDR_W-1:0]];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted_index    = rsp_granted_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_allocated_blocks = rsp_alloc_blk_ff;
   assign rsp_remaining_blocks = rsp_remain_blk_ff;
   assign rsp_allocated_bytes  = rsp_alloc_byt_ff;
   assign rsp_remaining_bytes  = rsp_remain_byt_ff;

endmodule

// ----- hw/rtl/fixed_block_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Pool allocator for equal-size blocks kept on a LIFO free list of links.
// ----------------------------------------------------------------------------
// Each request item gives exactly one response item, in order. A front stage
// decodes the command and feeds a two-entry queue; the back end then runs a
// free, clear or rejected command through the byte-count multiply and the
// response register, and a granted alloc first through a registered read of
// the link memory at the head; it takes no new item until the last one's
// response is registered. After reset, a block_count write or a clear command,
// the back end relinks the pool, writing one link memory entry per cycle for
// each block of the pool (256 after reset) before the next item is executed;
// requests are still queued meanwhile. Register writes are allowed only
// while no item is in flight.
module fixed_block_free_list_allocator_core #(
   parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fbfla_pkg::CMD_W-1:0]          req_command,
   input  logic [fbfla_pkg::IDX_W-1:0]          req_block_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fbfla_pkg::IDX_W-1:0]          rsp_granted_index,
   output logic [fbfla_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fbfla_pkg::COUNT_W-1:0]        rsp_allocated_blocks,
   output logic [fbfla_pkg::COUNT_W-1:0]        rsp_remaining_blocks,
   output logic [fbfla_pkg::BYTE_CNT_W-1:0]     rsp_allocated_bytes,
   output logic [fbfla_pkg::BYTE_CNT_W-1:0]     rsp_remaining_bytes,
   input  logic                                 csr_write_enable,
   input  logic [fbfla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbfla_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import fbfla_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   logic [COUNT_W-1:0] block_count_ff, block_count_in;
   logic [BYTES_W-1:0] block_bytes_ff, block_bytes_in;
   logic [CNT_W-1:0]   eff_count;
   logic [BYTES_W-1:0] eff_bytes;
   logic               relink;

   logic         push_valid, push_ready;
   op_entry_type push_entry;
   logic         pop_valid, pop_ready;
   op_entry_type pop_entry;

   assign relink = csr_write_enable && (csr_index == REG_BLOCK_COUNT);

   always_comb begin
      block_count_in = block_count_ff;
      block_bytes_in = block_bytes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_BLOCK_COUNT: block_count_in = COUNT_W'(csr_write_data);
            REG_BLOCK_BYTES: block_bytes_in = BYTES_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= RESET_BLOCK_COUNT;
         block_bytes_ff <= RESET_BLOCK_BYTES;
      end else begin
         block_count_ff <= block_count_in;
         block_bytes_ff <= block_bytes_in;
      end
   end

   always_comb begin
      if (block_count_ff == '0) eff_count = CNT_W'(1);
      else if (32'(block_count_ff) > MAX_BLOCKS) eff_count = CNT_W'(MAX_BLOCKS);
      else eff_count = CNT_W'(block_count_ff);
   end

   assign eff_bytes = (block_bytes_ff < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes_ff;

   fbfla_front #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_block_index (req_block_index),
      .eff_count       (eff_count),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_entry      (push_entry)
   );

   fbfla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   fbfla_back #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .eff_count            (eff_count),
      .eff_bytes            (eff_bytes),
      .relink               (relink),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_entry            (pop_entry),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_granted_index    (rsp_granted_index),
      .rsp_status           (rsp_status),
      .rsp_allocated_blocks (rsp_allocated_blocks),
      .rsp_remaining_blocks (rsp_remaining_blocks),
      .rsp_allocated_bytes  (rsp_allocated_bytes),
      .rsp_remaining_bytes  (rsp_remaining_bytes)
   );

endmodule

// ----- bench/tb_fixed_block_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator_core
// Self-checking bench for the fixed block free list pool allocator. A local
// model of the link memory, free head and allocated count predicts every
// response item as each request item is accepted; a checker compares the
// response fields in order. Directed items cover reset state, tiny pools,
// empty pool, bad frees, double frees and the unused command; random phases
// with varied pool settings follow, with back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import fbfla_pkg::*;

   localparam int POOL_BLOCKS = MAX_BLOCKS_DEFAULT;
   localparam int HOLD_CYCLES = 500;

   localparam logic [CMD_W-1:0]       CMD_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]      granted;
      logic [STATUS_W-1:0]   status;
      logic [COUNT_W-1:0]    alloc_blocks;
      logic [COUNT_W-1:0]    free_blocks;
      logic [BYTE_CNT_W-1:0] alloc_bytes;
      logic [BYTE_CNT_W-1:0] free_bytes;
   } pool_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_command = '0;
   logic [IDX_W-1:0]       req_block_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [IDX_W-1:0]       rsp_granted_index;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_W-1:0]     rsp_allocated_blocks;
   logic [COUNT_W-1:0]     rsp_remaining_blocks;
   logic [BYTE_CNT_W-1:0]  rsp_allocated_bytes;
   logic [BYTE_CNT_W-1:0]  rsp_remaining_bytes;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // pool model
   logic [COUNT_W-1:0] link_mem [POOL_BLOCKS];
   logic [COUNT_W-1:0] head_block;
   logic [COUNT_W-1:0] blocks_out;
   logic [COUNT_W-1:0] cfg_count;
   logic [BYTES_W-1:0] cfg_bytes;

   pool_report_type    expected_reports [$];
   logic [IDX_W-1:0]   granted_blocks [$];
   int                 errors = 0;
   bit                 sender_gaps = 1'b1;
   bit                 sink_stalls = 1'b1;
   bit                 hold_request = 1'b0;

   fixed_block_free_list_allocator_core #(
      .MAX_BLOCKS(POOL_BLOCKS)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_status          (rsp_status),
      .rsp_allocated_blocks(rsp_allocated_blocks),
      .rsp_remaining_blocks(rsp_remaining_blocks),
      .rsp_allocated_bytes (rsp_allocated_bytes),
      .rsp_remaining_bytes (rsp_remaining_bytes),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pool_size();
      if (cfg_count == 0) return 1;
      if (cfg_count > POOL_BLOCKS) return POOL_BLOCKS;
      return cfg_count;
   endfunction

   function automatic int unsigned block_unit();
      return (cfg_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg_bytes;
   endfunction

   task automatic relink_pool();
      int unsigned n;
      n = pool_size();
      for (int i = 0; i < POOL_BLOCKS; i++)
         link_mem[i] = (i + 1 < n) ? COUNT_W'(i + 1) : COUNT_W'(POOL_BLOCKS);
      head_block = '0;
      blocks_out = '0;
      granted_blocks.delete();
   endtask

   task automatic pool_predict(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
      pool_report_type rep;
      int unsigned     n;
      int unsigned     unit;
      int unsigned     left;
      logic [31:0]     prod;
      n = pool_size();
      unit = block_unit();
      rep = '0;
      rep.status = STATUS_OK;
      case (cmd)
         CMD_ALLOC: begin
            if (head_block >= POOL_BLOCKS || blocks_out >= n) begin
               rep.status = STATUS_EMPTY;
            end else begin
               rep.granted = head_block[IDX_W-1:0];
               granted_blocks.push_back(head_block[IDX_W-1:0]);
               head_block = link_mem[head_block[IDX_W-1:0]];
               blocks_out = blocks_out + 1'b1;
            end
         end
         CMD_FREE: begin
            if (idx >= n || blocks_out == 0) begin
               rep.status = STATUS_BAD_FREE;
            end else begin
               link_mem[idx] = head_block;
               head_block = {1'b0, idx};
               blocks_out = blocks_out - 1'b1;
               for (int k = 0; k < granted_blocks.size(); k++) begin
                  if (granted_blocks[k] == idx) begin
                     granted_blocks.delete(k);
                     break;
                  end
               end
            end
         end
         CMD_CLEAR: relink_pool();
         default: ;
      endcase
      left = (blocks_out <= n) ? n - blocks_out : 0;
      rep.alloc_blocks = blocks_out;
      rep.free_blocks = COUNT_W'(left);
      prod = blocks_out * unit;
      rep.alloc_bytes = prod[BYTE_CNT_W-1:0];
      prod = left * unit;
      rep.free_bytes = prod[BYTE_CNT_W-1:0];
      expected_reports.push_back(rep);
   endtask

   // called at a rising edge; returns at the edge the item is accepted
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
      int gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_block_index <= idx;
      do @(posedge clock); while (!req_ready);
      pool_predict(cmd, idx);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_BLOCK_COUNT) begin
         cfg_count = data[COUNT_W-1:0];
         relink_pool();
      end else if (idx == REG_BLOCK_BYTES) begin
         cfg_bytes = data;
      end
      @(posedge clock);
   endtask

   task automatic random_item(input int alloc_pct, input bit noisy);
      int               roll;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      roll = noisy ? $urandom_range(0, 99) : 100;
      idx = IDX_W'($urandom_range(0, 255));
      if (roll < 2) begin
         cmd = CMD_UNUSED;
      end else if (roll < 3) begin
         cmd = CMD_CLEAR;
      end else if (roll < 7) begin
         cmd = CMD_FREE;
      end else if ($urandom_range(0, 99) < alloc_pct) begin
         cmd = CMD_ALLOC;
      end else begin
         cmd = CMD_FREE;
         if (granted_blocks.size() != 0)
            idx = granted_blocks[$urandom_range(0, granted_blocks.size() - 1)];
      end
      send_item(cmd, idx);
   endtask

   task automatic pick_settings();
      logic [CSR_DATA_W-1:0] count_data;
      logic [CSR_DATA_W-1:0] bytes_data;
      count_data = CSR_DATA_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 6))
         0: count_data[COUNT_W-1:0] = 9'd0;
         1: count_data[COUNT_W-1:0] = 9'd1;
         2: count_data[COUNT_W-1:0] = 9'd2;
         3: count_data[COUNT_W-1:0] = 9'd255;
         4: count_data[COUNT_W-1:0] = 9'd256;
         5: count_data[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 256));
         default: count_data[COUNT_W-1:0] = COUNT_W'($urandom_range(257, 511));
      endcase
      case ($urandom_range(0, 3))
         0: bytes_data = CSR_DATA_W'($urandom_range(0, 7));
         1: bytes_data = MIN_BLOCK_BYTES;
         2: bytes_data = 16'hFFFF;
         default: bytes_data = CSR_DATA_W'($urandom_range(8, 65535));
      endcase
      drain();
      write_reg(REG_BLOCK_COUNT, count_data);
      write_reg(REG_BLOCK_BYTES, bytes_data);
   endtask

   task automatic test_reset_state();
      send_item(CMD_FREE, 8'd0);
      send_item(CMD_ALLOC, 8'hFF);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_UNUSED, 8'hFF);
      send_item(CMD_FREE, 8'd255);
      send_item(CMD_ALLOC, 8'h55);
      send_item(CMD_FREE, 8'd1);
      send_item(CMD_FREE, 8'd1);
      send_item(CMD_FREE, 8'd0);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_CLEAR, 8'hAA);
      send_item(CMD_ALLOC, 8'h00);
   endtask

   task automatic test_small_pools();
      drain();
      write_reg(REG_BLOCK_COUNT, 16'd3);
      write_reg(REG_BLOCK_BYTES, 16'd0);
      repeat (4) send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_FREE, 8'd3);
      send_item(CMD_FREE, 8'd255);
      send_item(CMD_FREE, 8'd2);
      send_item(CMD_ALLOC, 8'h00);
      drain();
      write_reg(REG_SPARE_2, 16'hFFFF);
      write_reg(REG_SPARE_3, 16'h1234);
      write_reg(REG_BLOCK_COUNT, 16'd0);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_FREE, 8'd0);
      send_item(CMD_FREE, 8'd0);
      drain();
      write_reg(REG_BLOCK_COUNT, 16'hFFFF);
      write_reg(REG_BLOCK_BYTES, 16'hFFFF);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_FREE, 8'd0);
      drain();
      write_reg(REG_BLOCK_BYTES, 16'd7);
      send_item(CMD_ALLOC, 8'h00);
   endtask

   task automatic test_back_pressure();
      drain();
      write_reg(REG_BLOCK_COUNT, CSR_DATA_W'(RESET_BLOCK_COUNT));
      write_reg(REG_BLOCK_BYTES, RESET_BLOCK_BYTES);
      sender_gaps = 1'b0;
      hold_request = 1'b1;
      repeat (40) random_item(50, 1'b0);
      sender_gaps = 1'b1;
   endtask

   task automatic test_full_pool();
      drain();
      write_reg(REG_BLOCK_COUNT, 16'd256);
      write_reg(REG_BLOCK_BYTES, 16'hFFFF);
      repeat (270) random_item(100, 1'b0);
      repeat (30) random_item(0, 1'b0);
   endtask

   task automatic test_random_phases();
      repeat (8) begin
         pick_settings();
         repeat (120) random_item($urandom_range(3, 9) * 10, 1'b1);
      end
   endtask

   task automatic test_steady_stream();
      pick_settings();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      repeat (100) random_item(60, 1'b1);
   endtask

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      pool_report_type exp_rep;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected response item, expected none, actual status %0d index %0d",
                     $time, rsp_status, rsp_granted_index);
            errors++;
         end else begin
            exp_rep = expected_reports.pop_front();
            check_field("granted_index", exp_rep.granted, rsp_granted_index);
            check_field("status", exp_rep.status, rsp_status);
            check_field("allocated_blocks", exp_rep.alloc_blocks, rsp_allocated_blocks);
            check_field("remaining_blocks", exp_rep.free_blocks, rsp_remaining_blocks);
            check_field("allocated_bytes", exp_rep.alloc_bytes, rsp_allocated_bytes);
            check_field("remaining_bytes", exp_rep.free_bytes, rsp_remaining_bytes);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      cfg_count = RESET_BLOCK_COUNT;
      cfg_bytes = RESET_BLOCK_BYTES;
      relink_pool();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_small_pools();
      test_back_pressure();
      test_full_pool();
      test_random_phases();
      test_steady_stream();
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_reports.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- fixed_block_free_list_allocator_core.f -----
hw/rtl/fbfla_pkg.sv
hw/rtl/fbfla_front.sv
hw/rtl/fbfla_queue.sv
hw/rtl/fbfla_back.sv
hw/rtl/fixed_block_free_list_allocator_core.sv
bench/tb_fixed_block_free_list_allocator_core.sv
